// ----- rtl/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg
// Types and constants shared by the quadratic root solver modules.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int DATA_W = 32;                       // coefficient and root width
  localparam int FRAC_W = 16;                       // fraction bits
  localparam int NUM_W  = DATA_W + 2 * FRAC_W + 3;  // divider dividend width
  localparam int DEN_W  = DATA_W + 1;               // divider divisor width
  localparam int RAD_W  = 2 * (DATA_W + FRAC_W + 2); // square root operand width
  localparam int ROOT_W = RAD_W / 2;                // square root result width
  localparam int DISC_W = 2 * DATA_W + 2;           // discriminant width

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_ALL   = 2'd1;
  localparam logic [1:0] ST_ROOTS = 2'd2;

  typedef enum logic [2:0] {
    K_NOREAL,
    K_INF,
    K_ZERO,
    K_LIN,
    K_BZERO,
    K_CZERO,
    K_GEN
  } kind_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] coef_a;
    logic signed [DATA_W-1:0] coef_b;
    logic signed [DATA_W-1:0] coef_c;
  } in_t;

  typedef struct packed {
    logic [1:0]               root_status;
    logic signed [DATA_W-1:0] root_one;
    logic signed [DATA_W-1:0] root_two;
    logic                     overflow_flag;
  } out_t;

  typedef struct packed {
    kind_e             kind;
    logic              sa;
    logic              sb;
    logic              sc;
    logic [DATA_W-1:0] ua;
    logic [DATA_W-1:0] ub;
    logic [DATA_W-1:0] uc;
  } item_t;

endpackage

// ----- rtl/qrs_front.sv -----
// ----------------------------------------------------------------------------
// qrs_front
// Splits coefficients into sign and magnitude, sorts out the degenerate
// cases and queues the words for the back end.
// ----------------------------------------------------------------------------
module qrs_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  qrs_pkg::in_t   coef_i,
  output logic           busy_o,
  input  logic           pop_i,
  output logic           item_valid_o,
  output qrs_pkg::item_t item_o
);
  import qrs_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t           mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  item_t           item;
  logic            push;

  always_comb begin
    item.sa = coef_i.coef_a[DATA_W-1];
    item.sb = coef_i.coef_b[DATA_W-1];
    item.sc = coef_i.coef_c[DATA_W-1];
    item.ua = item.sa ? -coef_i.coef_a : coef_i.coef_a;
    item.ub = item.sb ? -coef_i.coef_b : coef_i.coef_b;
    item.uc = item.sc ? -coef_i.coef_c : coef_i.coef_c;
    priority if (item.ua == '0) begin
      if (item.ub == '0) begin
        item.kind = (item.uc == '0) ? K_INF : K_NOREAL;
      end else begin
        item.kind = (item.uc == '0) ? K_ZERO : K_LIN;
      end
    end else if (item.ub == '0) begin
      priority if (item.uc == '0) begin
        item.kind = K_ZERO;
      end else if (item.sa == item.sc) begin
        item.kind = K_NOREAL;
      end else begin
        item.kind = K_BZERO;
      end
    end else if (item.uc == '0) begin
      item.kind = K_CZERO;
    end else begin
      item.kind = K_GEN;
    end
  end

  assign busy_o       = (cnt_q == CW'(QUEUE_DEPTH));
  assign push         = start_i && !busy_o;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

// ----- rtl/qrs_div.sv -----
// ----------------------------------------------------------------------------
// qrs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qrs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [qrs_pkg::NUM_W-1:0]  num_i,
  input  logic [qrs_pkg::DEN_W-1:0]  den_i,
  output logic                       done_o,
  output logic [qrs_pkg::NUM_W-1:0]  quot_o
);
  import qrs_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] nq_q, nq_d;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_q, nq_q[NUM_W-1]};
  assign fits    = (shifted >= {1'b0, den_q});

  always_comb begin
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    nq_d   = nq_q;
    if (start_i) begin
      cnt_d = '0;
      run_d = 1'b1;
      rem_d = '0;
      nq_d  = num_i;
    end else if (run_q) begin
      rem_d = fits ? DEN_W'(shifted - {1'b0, den_q}) : DEN_W'(shifted);
      nq_d  = {nq_q[NUM_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NUM_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = nq_q;

endmodule

// ----- rtl/qrs_sqrt.sv -----
// ----------------------------------------------------------------------------
// qrs_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module qrs_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [qrs_pkg::RAD_W-1:0]   rad_i,
  output logic                        done_o,
  output logic [qrs_pkg::ROOT_W-1:0]  root_o
);
  import qrs_pkg::*;

  localparam int CW = $clog2(ROOT_W + 1);

  logic [CW-1:0]     cnt_q, cnt_d;
  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [RAD_W-1:0]  xs_q, xs_d;
  logic [ROOT_W:0]   rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [ROOT_W+2:0] cur, trial;
  logic              fits;

  assign cur   = {rem_q, xs_q[RAD_W-1:RAD_W-2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign fits  = (cur >= trial);

  always_comb begin
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    xs_d   = xs_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      cnt_d  = '0;
      run_d  = 1'b1;
      xs_d   = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (run_q) begin
      xs_d   = {xs_q[RAD_W-3:0], 2'b00};
      rem_d  = fits ? (ROOT_W+1)'(cur - trial) : (ROOT_W+1)'(cur);
      root_d = {root_q[ROOT_W-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CW'(ROOT_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xs_q   <= xs_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- rtl/qrs_back.sv -----
// ----------------------------------------------------------------------------
// qrs_back
// Sequencer that pulls queued words and works out the roots with a shared
// multiplier step, square root unit and divider, then saturates the result.
// ----------------------------------------------------------------------------
module qrs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  qrs_pkg::item_t item_i,
  output logic           pop_o,
  output logic           done_o,
  output qrs_pkg::out_t  result_o
);
  import qrs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DISC = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DIV2 = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam int NS_W = ROOT_W + 2;
  localparam logic [NUM_W-1:0] SAT_LIM = NUM_W'(1) << (DATA_W - 1);

  logic [2:0]          state_q, state_d;
  item_t               it_q;
  logic [2*DATA_W-1:0] bb_q, ac_q;
  logic [NUM_W-1:0]    r1_q, r1_d, r2_q, r2_d;
  logic                n1_q, n1_d, n2_q, n2_d;
  logic [1:0]          st_q, st_d;
  logic                done_q;
  out_t                res_q, res_d;

  logic                div_start, div_done;
  logic [NUM_W-1:0]    div_num, div_q;
  logic [DEN_W-1:0]    div_den;
  logic                sq_start, sq_done;
  logic [RAD_W-1:0]    sq_rad;
  logic [ROOT_W-1:0]   sq_root;

  logic [DISC_W-1:0]   bbx, ac4, disc;
  logic                disc_neg;
  logic signed [NS_W-1:0] nb, n1s, n2s;
  logic [NS_W-1:0]     n1m, n2m;
  logic [DATA_W:0]     e1, e2;

  function automatic logic [DATA_W:0] sat_fn(logic neg, logic [NUM_W-1:0] mag);
    logic [DATA_W:0] r;
    begin
      if (!neg && mag >= SAT_LIM) begin
        r = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
      end else if (neg && mag > SAT_LIM) begin
        r = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        r = {1'b0, neg ? -mag[DATA_W-1:0] : mag[DATA_W-1:0]};
      end
      return r;
    end
  endfunction

  // discriminant and the two numerators -b -/+ s
  assign bbx      = DISC_W'(bb_q);
  assign ac4      = {ac_q, 2'b00};
  assign disc_neg = (it_q.sa == it_q.sc) && (bbx < ac4);
  assign disc     = (it_q.sa != it_q.sc) ? bbx + ac4 : bbx - ac4;
  assign nb       = it_q.sb ? $signed(NS_W'(it_q.ub)) : -$signed(NS_W'(it_q.ub));
  assign n1s      = nb - $signed(NS_W'(sq_root));
  assign n2s      = nb + $signed(NS_W'(sq_root));
  assign n1m      = n1s[NS_W-1] ? NS_W'(-n1s) : NS_W'(n1s);
  assign n2m      = n2s[NS_W-1] ? NS_W'(-n2s) : NS_W'(n2s);

  assign pop_o = (state_q == S_IDLE) && item_valid_i;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    sq_rad    = '0;
    if (pop_o) begin
      unique case (item_i.kind)
        K_LIN: begin
          div_start = 1'b1;
          div_num   = NUM_W'(item_i.uc) << FRAC_W;
          div_den   = DEN_W'(item_i.ub);
        end
        K_BZERO: begin
          div_start = 1'b1;
          div_num   = NUM_W'(item_i.uc) << (2 * FRAC_W);
          div_den   = DEN_W'(item_i.ua);
        end
        K_CZERO: begin
          div_start = 1'b1;
          div_num   = NUM_W'(item_i.ub) << FRAC_W;
          div_den   = DEN_W'(item_i.ua);
        end
        default: ;
      endcase
    end else if (state_q == S_SQRT && sq_done && it_q.kind == K_GEN) begin
      div_start = 1'b1;
      div_num   = NUM_W'(n1m) << FRAC_W;
      div_den   = {it_q.ua, 1'b0};
    end else if (state_q == S_DIV && div_done && it_q.kind == K_GEN) begin
      div_start = 1'b1;
      div_num   = NUM_W'(n2m) << FRAC_W;
      div_den   = {it_q.ua, 1'b0};
    end
    if (state_q == S_DISC && !disc_neg) begin
      sq_start = 1'b1;
      sq_rad   = RAD_W'(disc);
    end else if (state_q == S_DIV && div_done && it_q.kind == K_BZERO) begin
      sq_start = 1'b1;
      sq_rad   = RAD_W'(div_q);
    end
  end

  always_comb begin
    state_d = state_q;
    r1_d    = r1_q;
    r2_d    = r2_q;
    n1_d    = n1_q;
    n2_d    = n2_q;
    st_d    = st_q;
    e1      = sat_fn(n1_q, r1_q);
    e2      = sat_fn(n2_q, r2_q);
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          r1_d = '0;
          r2_d = '0;
          n1_d = 1'b0;
          n2_d = 1'b0;
          st_d = ST_ROOTS;
          unique case (item_i.kind)
            K_NOREAL: begin
              st_d    = ST_NONE;
              state_d = S_EMIT;
            end
            K_INF: begin
              st_d    = ST_ALL;
              state_d = S_EMIT;
            end
            K_ZERO:  state_d = S_EMIT;
            K_GEN:   state_d = S_MUL;
            K_LIN, K_BZERO, K_CZERO: state_d = S_DIV;
            default: state_d = S_EMIT;
          endcase
        end
      end
      S_MUL:  state_d = S_DISC;
      S_DISC: begin
        if (disc_neg) begin
          st_d    = ST_NONE;
          state_d = S_EMIT;
        end else begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          if (it_q.kind == K_GEN) begin
            state_d = S_DIV;
          end else begin
            r1_d    = NUM_W'(sq_root);
            r2_d    = NUM_W'(sq_root);
            n2_d    = (sq_root != '0);
            state_d = S_EMIT;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          unique case (it_q.kind)
            K_LIN: begin
              r1_d    = div_q;
              r2_d    = div_q;
              n1_d    = (!it_q.sc != it_q.sb) && (div_q != '0);
              n2_d    = n1_d;
              state_d = S_EMIT;
            end
            K_CZERO: begin
              r2_d    = div_q;
              n2_d    = (!it_q.sb != it_q.sa) && (div_q != '0);
              state_d = S_EMIT;
            end
            K_BZERO: state_d = S_SQRT;
            default: begin
              r1_d    = div_q;
              n1_d    = (n1s[NS_W-1] != it_q.sa) && (div_q != '0);
              state_d = S_DIV2;
            end
          endcase
        end
      end
      S_DIV2: begin
        if (div_done) begin
          r2_d    = div_q;
          n2_d    = (n2s[NS_W-1] != it_q.sa) && (div_q != '0);
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        res_d.root_status = st_q;
        if (st_q == ST_ROOTS) begin
          res_d.root_one      = e1[DATA_W-1:0];
          res_d.root_two      = e2[DATA_W-1:0];
          res_d.overflow_flag = e1[DATA_W] | e2[DATA_W];
        end else begin
          res_d.root_one      = '0;
          res_d.root_two      = '0;
          res_d.overflow_flag = 1'b0;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      it_q <= item_i;
    end
    if (state_q == S_MUL) begin
      bb_q <= it_q.ub * it_q.ub;
      ac_q <= it_q.ua * it_q.uc;
    end
    r1_q  <= r1_d;
    r2_q  <= r2_d;
    n1_q  <= n1_d;
    n2_q  <= n2_d;
    st_q  <= st_d;
    res_q <= res_d;
  end

  qrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef ASSERT_OFF
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe held two cycles");
  a_strobe_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == S_EMIT) else $error("strobe without emit");
  a_none_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.root_status != ST_ROOTS) |->
      (res_q.root_one == '0 && res_q.root_two == '0 && !res_q.overflow_flag))
    else $error("roots reported without root status");
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_start && sq_start)) else $error("divider and root unit started together");
`endif

endmodule

// ----- rtl/quadratic_root_solver.sv -----
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 in signed Q16.16, saturating results.
// ----------------------------------------------------------------------------
//  channel   ports                    handshake
//  command   start_i, coef_i, busy_o  taken when start_i is high, busy_o low
//  result    done_o, result_o         one-cycle strobe, no back-pressure
//
//  A front stage splits and classifies each word into a small queue; a
//  back sequencer works one word at a time.  Degenerate cases use no unit;
//  a linear or c = 0 equation uses the 67-step divider, b = 0 a divide
//  then the 50-step square root, the general case a multiply, the root
//  and two divides.  busy_o rises only when the queue is full.  Reset clears
//  the queue and the sequencer at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  qrs_pkg::in_t  coef_i,
  output logic          busy_o,
  output logic          done_o,
  output qrs_pkg::out_t result_o
);
  import qrs_pkg::*;

  item_t item;
  logic  item_valid;
  logic  pop;

  qrs_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .coef_i       (coef_i),
    .busy_o       (busy_o),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  qrs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .done_o       (done_o),
    .result_o     (result_o)
  );

endmodule

// ----- sim/tb_quadratic_root_solver.sv -----
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver
// Self-checking bench for the quadratic root solver. A bit-accurate root
// predictor computes the status and roots of every accepted word on wide
// integers; each result strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver;
  import qrs_pkg::*;

  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  DRAIN       = 400;
  localparam logic [127:0] SAT_LIM = 128'd1 << (DATA_W - 1);

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start_i = 1'b0;
  in_t   coef_i = '0;
  logic  busy_o;
  logic  done_o;
  out_t  result_o;

  out_t  pending_roots[$];
  int    mismatches = 0;
  int    cycles = 0;
  int    burst_left = 0;

  quadratic_root_solver u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .coef_i(coef_i),
    .busy_o(busy_o), .done_o(done_o), .result_o(result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [127:0] int_sqrt(logic [127:0] d);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= d) r = t;
    end
    return r;
  endfunction

  // sign-magnitude quotient (num << FRAC_W) / den, toward zero
  function automatic void frac_div(input logic nn, input logic [127:0] nm, input logic dn,
                                   input logic [127:0] dm, output logic qn,
                                   output logic [127:0] qm);
    qm = (nm << FRAC_W) / dm;
    qn = (nn != dn) && (qm != 0);
  endfunction

  function automatic void signed_sum(input logic n1, input logic [127:0] m1, input logic n2,
                                     input logic [127:0] m2, output logic nz,
                                     output logic [127:0] mz);
    if (n1 == n2) begin
      mz = m1 + m2;
      nz = n1;
    end else if (m1 >= m2) begin
      mz = m1 - m2;
      nz = n1;
    end else begin
      mz = m2 - m1;
      nz = n2;
    end
    if (mz == 0) nz = 1'b0;
  endfunction

  function automatic logic [DATA_W-1:0] clamp_root(logic neg, logic [127:0] m,
                                                   inout logic ovf);
    logic [127:0] v;
    if (!neg && m >= SAT_LIM) begin
      ovf = 1'b1;
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
    if (neg && m > SAT_LIM) begin
      ovf = 1'b1;
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    v = neg ? -m : m;
    return v[DATA_W-1:0];
  endfunction

  function automatic out_t predict_roots(in_t w);
    logic sa, sb, sc, n1, n2, nn, ovf;
    logic [DATA_W-1:0] ra, rb, rc;
    logic [127:0] ua, ub, uc, r1, r2, d, p, s, num;
    logic [1:0] status;
    out_t o;
    sa = w.coef_a[DATA_W-1];
    sb = w.coef_b[DATA_W-1];
    sc = w.coef_c[DATA_W-1];
    ra = sa ? -w.coef_a : w.coef_a;
    rb = sb ? -w.coef_b : w.coef_b;
    rc = sc ? -w.coef_c : w.coef_c;
    ua = ra; ub = rb; uc = rc;
    r1 = '0; r2 = '0; n1 = 1'b0; n2 = 1'b0; ovf = 1'b0;
    status = ST_ROOTS;
    if (ua == 0) begin
      if (ub == 0) status = (uc == 0) ? ST_ALL : ST_NONE;
      else if (uc != 0) begin
        frac_div(!sc, uc, sb, ub, n1, r1);
        n2 = n1;
        r2 = r1;
      end
    end else if (ub == 0) begin
      if (uc != 0) begin
        if (sa == sc) status = ST_NONE;
        else begin
          r1 = int_sqrt((uc << (2 * FRAC_W)) / ua);
          r2 = r1;
          n2 = (r2 != 0);
        end
      end
    end else if (uc == 0) begin
      frac_div(!sb, ub, sa, ua, n2, r2);
    end else begin
      d = ub * ub;
      p = (ua * uc) << 2;
      if (sa != sc) d = d + p;
      else if (d >= p) d = d - p;
      else status = ST_NONE;
      if (status == ST_ROOTS) begin
        s = int_sqrt(d);
        signed_sum(!sb, ub, s != 0, s, nn, num);
        frac_div(nn, num, sa, ua << 1, n1, r1);
        signed_sum(!sb, ub, 1'b0, s, nn, num);
        frac_div(nn, num, sa, ua << 1, n2, r2);
      end
    end
    o = '0;
    o.root_status = status;
    if (status == ST_ROOTS) begin
      o.root_one = clamp_root(n1, r1, ovf);
      o.root_two = clamp_root(n2, r2, ovf);
    end
    o.overflow_flag = ovf;
    return o;
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && done_o) begin
      if (pending_roots.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, result_o);
        mismatches++;
      end else begin
        want = pending_roots.pop_front();
        if (result_o.root_status !== want.root_status)
          $display("%0t root_status: expected %0d actual %0d", $time,
                   want.root_status, result_o.root_status);
        if (result_o.root_one !== want.root_one)
          $display("%0t root_one: expected %h actual %h", $time,
                   want.root_one, result_o.root_one);
        if (result_o.root_two !== want.root_two)
          $display("%0t root_two: expected %h actual %h", $time,
                   want.root_two, result_o.root_two);
        if (result_o.overflow_flag !== want.overflow_flag)
          $display("%0t overflow_flag: expected %b actual %b", $time,
                   want.overflow_flag, result_o.overflow_flag);
        if (result_o !== want) mismatches++;
      end
    end
  end

  // append one prediction at the tail of the expected queue
  task automatic add_expected(out_t o);
    pending_roots = {pending_roots, o};
  endtask

  // hold start through a burst, and between bursts usually drop it for a random gap
  task automatic send_word(in_t w);
    @(negedge clk_i);
    start_i <= 1'b1;
    coef_i  <= w;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    add_expected(predict_roots(w));
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk_i);
        start_i <= 1'b0;
        repeat ($urandom_range(0, 300)) @(negedge clk_i);
      end
    end
  endtask

  function automatic logic [DATA_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return $urandom_range(1, 8) << FRAC_W;
      2:       return -($urandom_range(1, 8) << FRAC_W);
      3:       return $signed(16'($urandom));
      4:       return {1'b1, {(DATA_W-1){1'b0}}};
      5:       return {1'b0, {(DATA_W-1){1'b1}}};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [DATA_W-1:0] mx, mn, one;
    mx  = {1'b0, {(DATA_W-1){1'b1}}};
    mn  = {1'b1, {(DATA_W-1){1'b0}}};
    one = 1 << FRAC_W;
    send_word('{0, 0, 0});                 // every x a root
    send_word('{0, 0, one});               // no root
    send_word('{0, 2 * one, -4 * one});    // linear
    send_word('{0, 1, mx});                // linear, saturates
    send_word('{0, one, 0});               // linear with zero c
    send_word('{one, 0, -4 * one});        // plus/minus sqrt
    send_word('{one, 0, 4 * one});         // b zero, no root
    send_word('{mx, 0, -1});               // sqrt rounds down to one LSB
    send_word('{one, 0, 0});               // b and c zero
    send_word('{one, 3 * one, 0});         // c zero
    send_word('{1, mx, 0});                // c zero, saturates
    send_word('{one, -2 * one, one});      // zero discriminant
    send_word('{one, -3 * one, 2 * one});  // two roots
    send_word('{one, one, one});           // negative discriminant
    send_word('{mn, mn, mn});
    send_word('{mx, mx, mx});
    send_word('{mn, mx, mx});
    send_word('{1, mn, 1});
    send_word('{-1, -1, -1});
    send_word('{mx, mn, 1});
  endtask

  task automatic test_double_roots(int n);
    int p, q;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(1, 200) * ($urandom_range(0, 1) ? 1 : -1);
      q = $urandom_range(1, 60) * ($urandom_range(0, 1) ? 1 : -1);
      send_word('{p, 2 * p * q, p * q * q});
    end
  endtask

  task automatic test_random(int n);
    in_t w;
    for (int i = 0; i < n; i++) begin
      w.coef_a = rand_coef();
      w.coef_b = rand_coef();
      w.coef_c = rand_coef();
      send_word(w);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_double_roots(100);
    test_random(1600);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
